@@ design/imuafp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package imuafp_pkg;

    localparam int unsigned FRAME_LEN  = 12;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned WORD_FIRST = 5;
    localparam int unsigned WORD_BYTES = 6;
    localparam int unsigned WIDX_W     = 3;

    localparam logic [7:0] SYNC_FIRST   = 8'hAA;
    localparam logic [7:0] SYNC_SECOND  = 8'h55;
    localparam logic [7:0] LEN_ATTITUDE = 8'h06;

    localparam logic [POS_W-1:0] POS_START  = 4'd0;
    localparam logic [POS_W-1:0] POS_RESYNC = 4'd2;
    localparam logic [POS_W-1:0] POS_LEN    = 4'd4;
    localparam logic [POS_W-1:0] POS_WFIRST = 4'd5;
    localparam logic [POS_W-1:0] POS_WLAST  = 4'd10;
    localparam logic [POS_W-1:0] POS_CSUM   = 4'd11;
    localparam logic [POS_W-1:0] POS_LIMIT  = 4'd12;

    typedef struct packed {
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [15:0] roll;
        logic [31:0] good_frames;
    } result_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
    } status_t;

endpackage
`default_nettype wire

@@ design/imuafp_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
module imuafp_core
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic [7:0]           data,
    output imuafp_pkg::result_t       res,
    output imuafp_pkg::status_t       stat
);

    logic [imuafp_pkg::POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic [7:0]                   prev_reg, prev_next;
    logic [7:0]                   sum_reg, sum_next;
    logic                         len_ok_reg, len_ok_next;
    logic [31:0]                  count_reg, count_next;
    logic [7:0]                   word_reg [imuafp_pkg::WORD_BYTES];
    logic [imuafp_pkg::WIDX_W-1:0] widx;
    logic                         resync, wrap, good, in_words;

    always_comb
    begin
        pos_eff  = (pos_reg >= imuafp_pkg::POS_LIMIT) ? imuafp_pkg::POS_START : pos_reg;
        resync   = (data == imuafp_pkg::SYNC_SECOND) && (prev_reg == imuafp_pkg::SYNC_FIRST);
        wrap     = !resync && (pos_eff == imuafp_pkg::POS_CSUM);
        good     = wrap && len_ok_reg && (sum_reg == data);
        in_words = (pos_eff >= imuafp_pkg::POS_WFIRST) && (pos_eff <= imuafp_pkg::POS_WLAST);
        widx     = imuafp_pkg::WIDX_W'(pos_eff - imuafp_pkg::POS_WFIRST);

        prev_next = data;
        if (resync)
            pos_next = imuafp_pkg::POS_RESYNC;
        else if (wrap)
            pos_next = imuafp_pkg::POS_START;
        else
            pos_next = pos_eff + 4'd1;

        if (resync || wrap)
            sum_next = 8'd0;
        else if (pos_eff >= imuafp_pkg::POS_RESYNC && pos_eff <= imuafp_pkg::POS_WLAST)
            sum_next = sum_reg + data;
        else
            sum_next = sum_reg;

        len_ok_next = (pos_eff == imuafp_pkg::POS_LEN) ? (data == imuafp_pkg::LEN_ATTITUDE)
                                                       : len_ok_reg;
        count_next  = good ? count_reg + 32'd1 : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= imuafp_pkg::POS_START;
            prev_reg   <= 8'd0;
            sum_reg    <= 8'd0;
            len_ok_reg <= 1'b0;
            count_reg  <= 32'd0;
        end
        else if (en)
        begin
            pos_reg    <= pos_next;
            prev_reg   <= prev_next;
            sum_reg    <= sum_next;
            len_ok_reg <= len_ok_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_words)
            word_reg[widx] <= data;
    end

    always_comb
    begin
        res.yaw         = {word_reg[1], word_reg[0]};
        res.pitch       = {word_reg[3], word_reg[2]};
        res.roll        = {word_reg[5], word_reg[4]};
        res.good_frames = count_next;
        stat.hit        = good;
        stat.pos        = pos_reg;
    end

endmodule
`default_nettype wire

@@ design/imu_attitude_frame_parser_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Attitude frame parser: one received byte per transfer, 12-byte frames resynchronised by
// 0xAA 0x55 at any point. A frame with length byte 6 and a matching 8-bit additive checksum
// gives one result (yaw, pitch, roll in centidegrees and a wrapping good-frame count); any
// other byte gives none. Each byte lands in an input register, is folded
// into the running checksum and frame state, and a result goes to an output register.
// Between byte transfer and result valid lie the input and output registers; one byte per cycle is sustained
// while the result side is not stalled.
module imu_attitude_frame_parser_top
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rx_valid,
    output logic                    rx_stall,
    input  wire logic [7:0]         rx_byte,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic        [15:0]      yaw_centideg,
    output logic signed [15:0]      pitch_centideg,
    output logic signed [15:0]      roll_centideg,
    output logic        [31:0]      good_frames
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  res_valid_reg;
    imuafp_pkg::result_t   res_reg;
    imuafp_pkg::result_t   core_res;
    imuafp_pkg::status_t   core_stat;
    logic                  advance, core_en;

    assign advance  = !res_valid_reg || !res_stall;
    assign core_en  = in_valid_reg && advance;
    assign rx_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!rx_stall)
            in_valid_reg <= rx_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
            in_byte_reg <= rx_byte;
    end

    imuafp_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (core_en),
        .data  (in_byte_reg),
        .res   (core_res),
        .stat  (core_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= core_en && core_stat.hit;
    end

    always_ff @(posedge clk)
    begin
        if (core_en && core_stat.hit)
            res_reg <= core_res;
    end

    assign res_valid      = res_valid_reg;
    assign yaw_centideg   = res_reg.yaw;
    assign pitch_centideg = $signed(res_reg.pitch);
    assign roll_centideg  = $signed(res_reg.roll);
    assign good_frames    = res_reg.good_frames;

    // frame position never leaves the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.pos < imuafp_pkg::POS_LIMIT)
        else $error("frame position out of range");

    // a good frame always closes the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        core_en && core_stat.hit |=> core_stat.pos == imuafp_pkg::POS_START && res_valid)
        else $error("good frame did not wrap or produce a result");

    // input side only holds off when a held result blocks it
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> in_valid_reg && res_valid_reg && res_stall)
        else $error("spurious input stall");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {FR_GOOD, FR_NOSYNC, FR_BADLEN, FR_BADSUM, FR_CUT, FR_NOISE} frame_kind_t;

    typedef struct {
        logic [7:0]          b;
        bit                  given;
        imuafp_pkg::result_t want;
    } byte_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               rx_valid = 1'b0;
    logic               rx_stall;
    logic [7:0]         rx_byte = 8'h00;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic        [15:0] yaw_centideg;
    logic signed [15:0] pitch_centideg;
    logic signed [15:0] roll_centideg;
    logic        [31:0] good_frames;

    // parser state as seen from the byte stream
    logic [7:0]  frame_bytes [imuafp_pkg::FRAME_LEN];
    int          frame_pos = 0;
    logic [7:0]  prior_byte = 8'h00;
    logic [31:0] frame_tally = 32'd0;

    imuafp_pkg::result_t attitude_q [$];
    byte_row_t   byte_rows [$];
    int          errors = 0;
    int          bytes_sent = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          stall_run = 0;
    int          stall_mode = 0;

    imu_attitude_frame_parser_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_valid       (rx_valid),
        .rx_stall       (rx_stall),
        .rx_byte        (rx_byte),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .yaw_centideg   (yaw_centideg),
        .pitch_centideg (pitch_centideg),
        .roll_centideg  (roll_centideg),
        .good_frames    (good_frames)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL imu_attitude_frame_parser_top");
            $finish;
        end
    end

    function automatic void parse_byte(input logic [7:0] b, output bit hit,
                                       output imuafp_pkg::result_t r);
        int         pos;
        logic [7:0] sum;
        pos = frame_pos;
        hit = 1'b0;
        r   = '0;
        if (pos >= imuafp_pkg::FRAME_LEN)
            pos = 0;
        frame_bytes[pos] = b;
        if (b == imuafp_pkg::SYNC_SECOND && prior_byte == imuafp_pkg::SYNC_FIRST)
        begin
            pos = 2;
            frame_bytes[0] = imuafp_pkg::SYNC_FIRST;
            frame_bytes[1] = imuafp_pkg::SYNC_SECOND;
        end
        else
        begin
            pos++;
        end
        prior_byte = frame_bytes[pos-1];
        if (pos >= imuafp_pkg::FRAME_LEN)
        begin
            frame_pos = 0;
            sum = 8'h00;
            for (int k = 2; k < 11; k++)
                sum = sum + frame_bytes[k];
            if (sum == frame_bytes[11] && frame_bytes[4] == imuafp_pkg::LEN_ATTITUDE)
            begin
                frame_tally   = frame_tally + 32'd1;
                r.yaw         = {frame_bytes[6], frame_bytes[5]};
                r.pitch       = {frame_bytes[8], frame_bytes[7]};
                r.roll        = {frame_bytes[10], frame_bytes[9]};
                r.good_frames = frame_tally;
                hit = 1'b1;
            end
        end
        else
        begin
            frame_pos = pos;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit given,
                             input imuafp_pkg::result_t want);
        bit                  hit;
        imuafp_pkg::result_t r;
        if (burst_left == 0)
        begin
            @(negedge clk);
            rx_valid <= 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
        end
        @(negedge clk);
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
        parse_byte(b, hit, r);
        if (given)
            attitude_q.push_back(want);
        else if (hit)
            attitude_q.push_back(r);
    endtask

    task automatic send_raw(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    task automatic add_row(input logic [7:0] b, input bit given,
                           input imuafp_pkg::result_t want);
        byte_row_t row;
        row.b     = b;
        row.given = given;
        row.want  = want;
        byte_rows.push_back(row);
    endtask

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 4))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0] fb [imuafp_pkg::FRAME_LEN];
        logic [7:0] sum;
        int         n;
        fb[0] = imuafp_pkg::SYNC_FIRST;
        fb[1] = imuafp_pkg::SYNC_SECOND;
        if (kind == FR_NOSYNC)
        begin
            fb[0] = 8'($urandom_range(0, 255));
            fb[1] = 8'($urandom_range(0, 255));
        end
        fb[2] = 8'($urandom_range(0, 255));
        fb[3] = 8'($urandom_range(0, 255));
        fb[4] = imuafp_pkg::LEN_ATTITUDE;
        if (kind == FR_BADLEN)
            fb[4] = imuafp_pkg::LEN_ATTITUDE ^ 8'($urandom_range(1, 255));
        for (int k = 5; k < 11; k++)
            fb[k] = pick_payload();
        sum = 8'h00;
        for (int k = 2; k < 11; k++)
            sum = sum + fb[k];
        fb[11] = sum;
        if (kind == FR_BADSUM)
            fb[11] = sum ^ 8'($urandom_range(1, 255));
        n = imuafp_pkg::FRAME_LEN;
        if (kind == FR_CUT)
            n = $urandom_range(3, 11);
        if (kind == FR_NOISE)
        begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
            begin
                case ($urandom_range(0, 2))
                    0: send_raw(imuafp_pkg::SYNC_FIRST);
                    1: send_raw(imuafp_pkg::SYNC_SECOND);
                    default: send_raw(8'($urandom_range(0, 255)));
                endcase
            end
        end
        else
        begin
            for (int k = 0; k < n; k++)
                send_raw(fb[k]);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        rx_valid <= 1'b0;
        burst_left = 0;
        while (attitude_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver back-pressure: runs of no stall, light, heavy and long stalls
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(10, 80);
        end
        stall_run--;
        case (stall_mode)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 3) == 0);
            2: res_stall <= 1'($urandom_range(0, 1));
            default: res_stall <= ((stall_run % 24) < 18);
        endcase
    end

    always @(posedge clk)
    begin
        imuafp_pkg::result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (attitude_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result yaw=%h pitch=%h roll=%h count=%0d",
                         $time, yaw_centideg, pitch_centideg, roll_centideg, good_frames);
            end
            else
            begin
                want = attitude_q.pop_front();
                results_seen++;
                if (yaw_centideg !== want.yaw)
                begin
                    errors++;
                    $display("%0t: yaw expected %h actual %h", $time, want.yaw, yaw_centideg);
                end
                if (pitch_centideg !== want.pitch)
                begin
                    errors++;
                    $display("%0t: pitch expected %h actual %h",
                             $time, want.pitch, pitch_centideg);
                end
                if (roll_centideg !== want.roll)
                begin
                    errors++;
                    $display("%0t: roll expected %h actual %h", $time, want.roll, roll_centideg);
                end
                if (good_frames !== want.good_frames)
                begin
                    errors++;
                    $display("%0t: good_frames expected %0d actual %0d",
                             $time, want.good_frames, good_frames);
                end
            end
        end
    end

    initial
    begin
        int  pick;
        bit  paused;
        paused = 1'b0;
        for (int k = 0; k < imuafp_pkg::FRAME_LEN; k++)
            frame_bytes[k] = 8'h00;

        // extreme angles, then a resync mid-frame into an all-zero frame
        add_row(imuafp_pkg::SYNC_FIRST, 1'b0, '0);
        add_row(imuafp_pkg::SYNC_SECOND, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(imuafp_pkg::LEN_ATTITUDE, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'h80, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        add_row(8'h7F, 1'b0, '0);
        add_row(8'h02, 1'b1, '{16'hFFFF, 16'h8000, 16'h7FFF, 32'd1});
        add_row(8'h00, 1'b0, '0);
        add_row(imuafp_pkg::SYNC_FIRST, 1'b0, '0);
        add_row(imuafp_pkg::SYNC_SECOND, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(imuafp_pkg::LEN_ATTITUDE, 1'b0, '0);
        for (int k = 0; k < 6; k++)
            add_row(8'h00, 1'b0, '0);
        add_row(8'h06, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 32'd2});

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (byte_rows[i])
            send_byte(byte_rows[i].b, byte_rows[i].given, byte_rows[i].want);

        while (bytes_sent < 1600)
        begin
            if (!paused && bytes_sent > 800)
            begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_frame(FR_GOOD);
            else if (pick < 65)
                send_frame(FR_NOSYNC);
            else if (pick < 73)
                send_frame(FR_BADLEN);
            else if (pick < 81)
                send_frame(FR_BADSUM);
            else if (pick < 91)
                send_frame(FR_CUT);
            else
                send_frame(FR_NOISE);
        end

        drain_results();
        repeat (8) @(posedge clk);
        $display("Sent %0d bytes: good, unsynced, bad-length, bad-checksum, cut and noise frames",
                 bytes_sent);
        $display("Checked %0d attitude results, %0d mismatches", results_seen, errors);
        if (errors == 0 && attitude_q.size() == 0)
            $display("PASS imu_attitude_frame_parser_top");
        else
            $display("FAIL imu_attitude_frame_parser_top");
        $finish;
    end

endmodule

@@ filelist.f @@
design/imuafp_pkg.sv
design/imuafp_core.sv
design/imu_attitude_frame_parser_top.sv
tb/tb.sv
